/* sv/dhs_pkg.sv */
`timescale 1ns / 1ps
// dhs_pkg: shared types, register map and helpers for the debounced hold stopwatch
// no dependencies; used by the interfaces and all modules

package dhs_pkg;

    localparam int CntW    = 16;
    localparam int SecW    = 7;
    localparam int DigitW  = 4;
    localparam int AddrW   = 4;
    localparam int DataW   = 32;

    // register byte addresses
    localparam logic [AddrW-1:0] RegDebounce = 4'h0;
    localparam logic [AddrW-1:0] RegTps      = 4'h4;
    localparam logic [AddrW-1:0] RegLimit    = 4'h8;

    localparam logic [CntW-1:0] DebounceReset = 16'd20;
    localparam logic [CntW-1:0] TpsReset      = 16'd1000;
    localparam logic [SecW-1:0] LimitReset    = 7'd99;
    localparam logic [CntW-1:0] CntMax        = 16'hFFFF;

    // reciprocal of ten, exact for all 7-bit values
    localparam logic [7:0] RecipTen  = 8'd205;
    localparam int         RecipSh   = 11;

    typedef struct packed {
        logic [CntW-1:0] debounce_ticks;
        logic [CntW-1:0] ticks_per_second;
        logic [SecW-1:0] seconds_limit;
    } t_cfg;

    typedef struct packed {
        logic              running;
        logic [SecW-1:0]   seconds_count;
        logic [DigitW-1:0] tens_digit;
        logic [DigitW-1:0] ones_digit;
        logic              second_event;
        logic              switch_event;
    } t_result;

    function automatic logic [DigitW-1:0] tens_of(input logic [SecW-1:0] v);
        logic [SecW+7:0] prod;
        begin
            prod = {8'd0, v} * {{SecW{1'b0}}, RecipTen};
            tens_of = DigitW'(prod >> RecipSh);
        end
    endfunction

    function automatic logic [DigitW-1:0] ones_of(input logic [SecW-1:0] v);
        logic [SecW-1:0] tens10;
        begin
            tens10 = SecW'({tens_of(v), 3'b000}) + SecW'({tens_of(v), 1'b0});
            ones_of = DigitW'(v - tens10);
        end
    endfunction

endpackage

/* sv/dhs_if.sv */
`timescale 1ns / 1ps
// dhs_tick_if / dhs_result_if: valid/ready channels for tick items and result items
// depends on dhs_pkg

interface dhs_tick_if;
    logic valid;
    logic ready;
    logic switch_level;

    modport source (output valid, output switch_level, input ready);
    modport sink   (input valid, input switch_level, output ready);
endinterface

interface dhs_result_if;
    logic                        valid;
    logic                        ready;
    logic                        running;
    logic [dhs_pkg::SecW-1:0]    seconds_count;
    logic [dhs_pkg::DigitW-1:0]  tens_digit;
    logic [dhs_pkg::DigitW-1:0]  ones_digit;
    logic                        second_event;
    logic                        switch_event;

    modport source (output valid, output running, output seconds_count, output tens_digit,
                    output ones_digit, output second_event, output switch_event,
                    input ready);
    modport sink   (input valid, input running, input seconds_count, input tens_digit,
                    input ones_digit, input second_event, input switch_event,
                    output ready);
endinterface

/* sv/dhs_apb_regs.sv */
`timescale 1ns / 1ps
// dhs_apb_regs: apb configuration registers (debounce, ticks per second, limit)
// depends on dhs_pkg

module dhs_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dhs_pkg::AddrW-1:0]   paddr,
    input  logic [dhs_pkg::DataW-1:0]   pwdata,
    output logic [dhs_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output dhs_pkg::t_cfg               o_cfg
);

    dhs_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= dhs_pkg::DebounceReset;
            r_cfg.ticks_per_second <= dhs_pkg::TpsReset;
            r_cfg.seconds_limit    <= dhs_pkg::LimitReset;
        end else if (wr_en) begin
            case (paddr)
                dhs_pkg::RegDebounce: begin
                    r_cfg.debounce_ticks <= pwdata[dhs_pkg::CntW-1:0];
                end
                dhs_pkg::RegTps: begin
                    r_cfg.ticks_per_second <= pwdata[dhs_pkg::CntW-1:0];
                end
                dhs_pkg::RegLimit: begin
                    r_cfg.seconds_limit <= pwdata[dhs_pkg::SecW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            dhs_pkg::RegDebounce: prdata = {16'd0, r_cfg.debounce_ticks};
            dhs_pkg::RegTps:      prdata = {16'd0, r_cfg.ticks_per_second};
            dhs_pkg::RegLimit:    prdata = {25'd0, r_cfg.seconds_limit};
            default:              prdata = '0;
        endcase
    end

endmodule

/* sv/dhs_core.sv */
`timescale 1ns / 1ps
// dhs_core: debounce and stopwatch state, next-state and result logic for one tick
// depends on dhs_pkg

module dhs_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dhs_pkg::t_cfg      i_cfg,
    input  logic               i_advance,
    input  logic               i_level,
    output dhs_pkg::t_result   o_result
);

    logic                        r_raw_level,    n_raw_level;
    logic                        r_stable_level, n_stable_level;
    logic [dhs_pkg::CntW-1:0]    r_stable_cnt,   n_stable_cnt;
    logic                        r_timing,       n_timing;
    logic [dhs_pkg::CntW-1:0]    r_sub,          n_sub;
    logic [dhs_pkg::SecW-1:0]    r_sec,          n_sec;

    logic                        sw_ev;
    logic                        sec_ev;
    logic [dhs_pkg::CntW:0]      sub_inc;

    always_comb begin
        n_raw_level    = r_raw_level;
        n_stable_level = r_stable_level;
        n_stable_cnt   = r_stable_cnt;
        n_timing       = r_timing;
        n_sub          = r_sub;
        n_sec          = r_sec;
        sw_ev          = 1'b0;
        sec_ev         = 1'b0;
        sub_inc        = {1'b0, r_sub} + 1'b1;

        // debounce
        if (i_level != r_raw_level) begin
            n_raw_level  = i_level;
            n_stable_cnt = '0;
        end else begin
            if (r_stable_cnt != dhs_pkg::CntMax) begin
                n_stable_cnt = r_stable_cnt + 1'b1;
            end
            if (r_stable_level != r_raw_level && n_stable_cnt >= i_cfg.debounce_ticks) begin
                n_stable_level = r_raw_level;
                sw_ev          = 1'b1;
            end
        end

        // accumulate with the flag held before this tick
        if (r_timing) begin
            if (sub_inc >= {1'b0, i_cfg.ticks_per_second}) begin
                n_sub  = '0;
                sec_ev = 1'b1;
                if (r_sec < i_cfg.seconds_limit) begin
                    n_sec = r_sec + 1'b1;
                end
            end else begin
                n_sub = sub_inc[dhs_pkg::CntW-1:0];
            end
        end

        // debounced edge: press clears seconds, release clears sub-second count
        if (sw_ev) begin
            n_timing = n_stable_level;
            if (n_stable_level) begin
                n_sec = '0;
            end else begin
                n_sub = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_level    <= 1'b0;
            r_stable_level <= 1'b0;
            r_stable_cnt   <= '0;
            r_timing       <= 1'b0;
            r_sub          <= '0;
            r_sec          <= '0;
        end else if (i_advance) begin
            r_raw_level    <= n_raw_level;
            r_stable_level <= n_stable_level;
            r_stable_cnt   <= n_stable_cnt;
            r_timing       <= n_timing;
            r_sub          <= n_sub;
            r_sec          <= n_sec;
        end
    end

    always_comb begin
        o_result.running       = n_timing;
        o_result.seconds_count = n_sec;
        o_result.tens_digit    = dhs_pkg::tens_of(n_sec);
        o_result.ones_digit    = dhs_pkg::ones_of(n_sec);
        o_result.second_event  = sec_ev;
        o_result.switch_event  = sw_ev;
    end

    // timing always mirrors the debounced level
    a_timing_follows_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timing == r_stable_level)
        else $error("timing flag differs from debounced level");

    // sub-second count sits at zero while stopped
    a_sub_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timing |-> (r_sub == '0))
        else $error("sub-second count nonzero while stopped");

    // debounced level only moves to the raw level
    a_stable_to_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stable_level != $past(r_stable_level)) |-> (r_stable_level == r_raw_level))
        else $error("debounced level changed away from raw level");

    // seconds only step by one or clear
    a_sec_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sec != $past(r_sec)) |->
            (r_sec == '0 || r_sec == dhs_pkg::SecW'($past(r_sec) + 1'b1)))
        else $error("seconds value jumped");

endmodule

/* sv/debounced_hold_stopwatch_top.sv */
`timescale 1ns / 1ps
// debounced_hold_stopwatch_top: tick input register, core update, result register
// a tick is held in the input register, its result in the result register
// throughput: one tick transaction per cycle while the result sink is ready
// reset: synchronous active-low; clears valid and core state, config to 20/1000/99
// depends on dhs_pkg, dhs_if, dhs_apb_regs, dhs_core

module debounced_hold_stopwatch_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dhs_pkg::AddrW-1:0]   paddr,
    input  logic [dhs_pkg::DataW-1:0]   pwdata,
    output logic [dhs_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    // streams
    dhs_tick_if.sink                    i_tick,
    dhs_result_if.source                o_result
);

    dhs_pkg::t_cfg    cfg;
    dhs_pkg::t_result core_res;

    // input stage
    logic             r_in_valid;
    logic             r_in_level;
    // result stage
    logic             r_out_valid;
    dhs_pkg::t_result r_out;

    logic             out_free;   // result stage can take a new transaction
    logic             advance;    // input stage moves through the core this cycle
    logic             in_ready;

    dhs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the core state advances exactly once per tick, when it hands its result on
    dhs_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_level   (r_in_level),
        .o_result  (core_res)
    );

    assign out_free = !r_out_valid || o_result.ready;
    assign advance  = r_in_valid && out_free;
    // input stage takes a new tick when empty or draining this cycle
    assign in_ready = !r_in_valid || out_free;

    assign i_tick.ready = in_ready;

    // input register: valid is control, level is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_tick.valid) begin
            r_in_level <= i_tick.switch_level;
        end
    end

    // result register: holds a finished result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.running       = r_out.running;
    assign o_result.seconds_count = r_out.seconds_count;
    assign o_result.tens_digit    = r_out.tens_digit;
    assign o_result.ones_digit    = r_out.ones_digit;
    assign o_result.second_event  = r_out.second_event;
    assign o_result.switch_event  = r_out.switch_event;

endmodule
